// ----- rtl/core/swt_pkg.sv -----
// Shared types and constants for the sequence window tracker.
`default_nettype none
package swt_pkg;
    localparam int SeqW = 64;
    localparam int WinBits = 64;
    localparam int LimitW = 5;

    typedef enum logic [2:0] {
        ST_UNTRACKED = 3'd0,
        ST_FIRST     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_IN_ORDER  = 3'd3,
        ST_GAP       = 3'd4,
        ST_REORDERED = 3'd5
    } status_t;

    typedef struct packed {
        logic [SeqW-1:0] source_key;
        logic [SeqW-1:0] seq_number;
    } in_beat_t;

    typedef struct packed {
        status_t         status;
        logic [SeqW-1:0] echoed_sequence;
        logic [SeqW-1:0] missed_count;
        logic [SeqW-1:0] total_packets;
        logic [SeqW-1:0] total_untracked;
        logic [SeqW-1:0] total_first;
        logic [SeqW-1:0] total_duplicate;
        logic [SeqW-1:0] total_in_order;
        logic [SeqW-1:0] total_gap;
        logic [SeqW-1:0] total_reordered;
        logic [SeqW-1:0] total_missed;
    } out_beat_t;
endpackage
`default_nettype wire

// ----- rtl/core/swt_if.sv -----
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface swt_in_if;
    logic                    valid;
    logic                    ready;
    swt_pkg::in_beat_t       payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface swt_out_if;
    logic                    valid;
    logic                    ready;
    swt_pkg::out_beat_t      payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/swt_counters.sv -----
// Class counters and saturating missed total.
`default_nettype none
module swt_counters (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      upd,
    input  wire swt_pkg::status_t          status,
    input  wire logic [swt_pkg::SeqW-1:0]  missed,
    output swt_pkg::out_beat_t             totals
);
    import swt_pkg::*;
    logic [SeqW-1:0] pk_reg, un_reg, fi_reg, du_reg, io_reg, gp_reg, ro_reg, ms_reg;
    logic [SeqW:0]   ms_sum;

    assign ms_sum = {1'b0, ms_reg} + {1'b0, missed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_reg <= '0; un_reg <= '0; fi_reg <= '0; du_reg <= '0;
            io_reg <= '0; gp_reg <= '0; ro_reg <= '0; ms_reg <= '0;
        end
        else if (upd)
        begin
            pk_reg <= pk_reg + 1'b1;
            case (status)
                ST_UNTRACKED: un_reg <= un_reg + 1'b1;
                ST_FIRST:     fi_reg <= fi_reg + 1'b1;
                ST_DUPLICATE: du_reg <= du_reg + 1'b1;
                ST_IN_ORDER:  io_reg <= io_reg + 1'b1;
                ST_GAP:
                begin
                    gp_reg <= gp_reg + 1'b1;
                    ms_reg <= ms_sum[SeqW] ? '1 : ms_sum[SeqW-1:0];
                end
                default:      ro_reg <= ro_reg + 1'b1;
            endcase
        end
    end

    always_comb
    begin
        totals = '0;
        totals.total_packets   = pk_reg;
        totals.total_untracked = un_reg;
        totals.total_first     = fi_reg;
        totals.total_duplicate = du_reg;
        totals.total_in_order  = io_reg;
        totals.total_gap       = gp_reg;
        totals.total_reordered = ro_reg;
        totals.total_missed    = ms_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/core/sequence_window_tracker_unit.sv -----
// Sequence window tracker: per-stream classifier with 64-bit replay window.
// Flow: the key match sits in the cycle that takes the input beat; the entry is
// then read, then updated, and the result is held valid until it is taken.
// One beat at a time: read, update, result hand-off and return to idle. Next
// input taken the cycle after the result leaves.
// Reset: table empty, all counters zero, source_limit 16. No clearing pass.
`default_nettype none
module sequence_window_tracker_unit #(
    parameter int SOURCES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    swt_in_if.sink                            in_ch,
    swt_out_if.source                         out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [swt_pkg::LimitW-1:0]   cfg_wdata
);
    import swt_pkg::*;
    localparam int IdxW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CntW = $clog2(SOURCES + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_UPD, S_OUT} state_t;
    typedef struct packed {
        logic [SeqW-1:0] highest;
        logic [SeqW-1:0] window;
    } entry_t;

    state_t                state_reg;
    logic [LimitW-1:0]     limit_reg;
    logic [SOURCES-1:0]    valid_reg;
    logic [SOURCES-1:0][SeqW-1:0] key_reg;
    logic [CntW-1:0]       count_reg;
    entry_t                mem [SOURCES];
    entry_t                rd_reg;
    logic [SeqW-1:0]       skey_reg, seq_reg;
    logic                  hit_reg;
    logic [IdxW-1:0]       idx_reg;
    status_t               st_reg;
    logic [SeqW-1:0]       missed_reg;
    logic                  oval_reg;

    // Key match over the registered key array
    logic                  hit;
    logic [IdxW-1:0]       hit_idx;
    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = SOURCES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == in_ch.payload.source_key)
            begin
                hit = 1'b1;
                hit_idx = IdxW'(i);
            end
        end
    end

    logic [CntW-1:0] eff_limit;
    always_comb
    begin
        if ({{(32-LimitW){1'b0}}, limit_reg} > 32'(SOURCES))
            eff_limit = CntW'(SOURCES);
        else
            eff_limit = CntW'(limit_reg);
    end

    // Update decision
    logic [SeqW-1:0] fwd, back;
    status_t         st_next;
    logic [SeqW-1:0] missed_next;
    entry_t          wr_next;
    logic            wr_en;
    always_comb
    begin
        fwd = seq_reg - rd_reg.highest;
        back = rd_reg.highest - seq_reg;
        st_next = ST_REORDERED;
        missed_next = '0;
        wr_next = rd_reg;
        wr_en = 1'b0;
        if (!hit_reg)
        begin
            if (count_reg < eff_limit)
            begin
                st_next = ST_FIRST;
                wr_next.highest = seq_reg;
                wr_next.window = 64'd1;
                wr_en = 1'b1;
            end
            else
                st_next = ST_UNTRACKED;
        end
        else if (fwd == '0)
            st_next = ST_DUPLICATE;
        else if (!fwd[SeqW-1])
        begin
            wr_en = 1'b1;
            wr_next.highest = seq_reg;
            wr_next.window = (fwd[SeqW-1:6] != '0) ? 64'd1
                           : ((rd_reg.window << fwd[5:0]) | 64'd1);
            if (fwd == 64'd1)
                st_next = ST_IN_ORDER;
            else
            begin
                st_next = ST_GAP;
                missed_next = fwd - 1'b1;
            end
        end
        else if (back[SeqW-1:6] == '0)
        begin
            if (rd_reg.window[back[5:0]])
                st_next = ST_DUPLICATE;
            else
            begin
                wr_en = 1'b1;
                wr_next.window[back[5:0]] = 1'b1;
            end
        end
    end

    logic [IdxW-1:0] wr_idx;
    assign wr_idx = hit_reg ? idx_reg : count_reg[IdxW-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_reg <= mem[idx_reg];
        if (state_reg == S_UPD && wr_en)
            mem[wr_idx] <= wr_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            skey_reg <= in_ch.payload.source_key;
            seq_reg  <= in_ch.payload.seq_number;
            idx_reg  <= hit_idx;
        end
        if (state_reg == S_UPD)
        begin
            st_reg <= st_next;
            missed_reg <= missed_next;
            if (!hit_reg && st_next == ST_FIRST)
                key_reg[count_reg[IdxW-1:0]] <= skey_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= LimitW'(16);
            valid_reg <= '0;
            count_reg <= '0;
            hit_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        hit_reg <= hit;
                        state_reg <= S_READ;
                    end
                S_READ: state_reg <= S_UPD;
                S_UPD:
                begin
                    if (!hit_reg && st_next == ST_FIRST)
                    begin
                        valid_reg[count_reg[IdxW-1:0]] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                    oval_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                    begin
                        oval_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    out_beat_t totals;
    swt_counters u_cnt (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (state_reg == S_UPD),
        .status (st_next),
        .missed (missed_next),
        .totals (totals)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = oval_reg;
    always_comb
    begin
        out_ch.payload = totals;
        out_ch.payload.status = st_reg;
        out_ch.payload.echoed_sequence = seq_reg;
        out_ch.payload.missed_count = missed_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/core/swt_checker.sv -----
// Port-level checks for the tracker, bound to the top level.
`default_nettype none
module swt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [63:0] total_packets,
    input wire logic [2:0]  status,
    input wire logic [63:0] missed_count
);
    import swt_pkg::*;

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_missed_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_GAP |-> missed_count == 64'd0)
        else $error("missed count on non-gap");
    a_pkts_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> ##1 $stable(total_packets))
        else $error("counter moved without a beat");
endmodule

bind sequence_window_tracker_unit swt_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .total_packets (out_ch.payload.total_packets),
    .status        (out_ch.payload.status),
    .missed_count  (out_ch.payload.missed_count)
);
`default_nettype wire
